// ----- sv/hmcg_pkg.sv -----
// Shared types, constants and helper functions of the hemisphere mesh cell generator.
// Used by every module of the block; depends on nothing else.
package hmcg_pkg;

    // Working width of the CORDIC datapath (Q30 values with growth and sign).
    localparam int CW = 34;
    typedef logic signed [CW-1:0] cw_t;

    localparam int CORDIC_STEPS = 30;
    localparam int STEP_W       = 5;
    typedef logic [STEP_W-1:0] step_t;

    localparam int POS_W = 25;
    localparam int UV_W  = 17;

    localparam cw_t Q30_ONE   = 34'sd1073741824;
    localparam cw_t HALF_TURN = 34'sd2147483648;
    localparam cw_t CORDIC_K  = 34'sd652032874;

    // One full turn in 1/128 degree, and the factors of the turn conversion.
    // b = r * 2^32 / 46080 is split as r * 93206 + (34 * r + 22) / 45, the
    // last quotient taken with a reciprocal multiply.
    localparam logic [18:0] FULL_ANGLE = 19'd46080;
    localparam logic [16:0] TURN_MUL   = 17'd93206;
    localparam logic [20:0] FIX_MUL    = 21'd34;
    localparam logic [20:0] FIX_ADD    = 21'd22;
    localparam logic [26:0] RECIP_45   = 27'd95443718;

    localparam logic [15:0] RADIUS_RESET  = 16'd100;
    localparam logic [15:0] AZ_STEP_RESET = 16'd1280;
    localparam logic [13:0] EL_STEP_RESET = 14'd1280;

    typedef enum logic [1:0] {
        REG_RADIUS  = 2'd0,
        REG_AZ_STEP = 2'd1,
        REG_EL_STEP = 2'd2
    } cfg_reg_t;

    // Words that travel beside the CORDIC lanes.
    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
        logic [31:0]      aux;
    } side_t;

    // One finished corner.
    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
        logic [UV_W-1:0]  tex_u;
        logic [UV_W-1:0]  tex_v;
    } corner_t;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [31:0] atan_of(input step_t i);
        logic [31:0] a;
        case (i)
            5'd0:  a = 32'd536870912;
            5'd1:  a = 32'd316933406;
            5'd2:  a = 32'd167458907;
            5'd3:  a = 32'd85004756;
            5'd4:  a = 32'd42667331;
            5'd5:  a = 32'd21354465;
            5'd6:  a = 32'd10679838;
            5'd7:  a = 32'd5340245;
            5'd8:  a = 32'd2670163;
            5'd9:  a = 32'd1335087;
            5'd10: a = 32'd667544;
            5'd11: a = 32'd333772;
            5'd12: a = 32'd166886;
            5'd13: a = 32'd83443;
            5'd14: a = 32'd41722;
            5'd15: a = 32'd20861;
            5'd16: a = 32'd10430;
            5'd17: a = 32'd5215;
            5'd18: a = 32'd2608;
            5'd19: a = 32'd1304;
            5'd20: a = 32'd652;
            5'd21: a = 32'd326;
            5'd22: a = 32'd163;
            5'd23: a = 32'd81;
            5'd24: a = 32'd41;
            5'd25: a = 32'd20;
            5'd26: a = 32'd10;
            5'd27: a = 32'd5;
            5'd28: a = 32'd3;
            5'd29: a = 32'd1;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

endpackage

// ----- sv/hmcg_cordic_cell.sv -----
// One CORDIC iteration with its output registers, rotation or vectoring mode.
// Depends on hmcg_pkg.
module hmcg_cordic_cell (
    input  logic            clk,
    input  logic            en,
    input  logic            vectoring,
    input  hmcg_pkg::step_t step,
    input  hmcg_pkg::cw_t   x_in,
    input  hmcg_pkg::cw_t   y_in,
    input  hmcg_pkg::cw_t   z_in,
    output hmcg_pkg::cw_t   x_out,
    output hmcg_pkg::cw_t   y_out,
    output hmcg_pkg::cw_t   z_out
);

    hmcg_pkg::cw_t x_reg, y_reg, z_reg;
    hmcg_pkg::cw_t x_next, y_next, z_next;
    hmcg_pkg::cw_t xs, ys, ang;
    logic          ccw;

    always_comb
    begin
        xs  = x_in >>> step;
        ys  = y_in >>> step;
        ang = {2'b00, hmcg_pkg::atan_of(step)};
        // Rotation drives z to zero, vectoring drives y to zero.
        ccw = vectoring ? y_in[hmcg_pkg::CW-1] : !z_in[hmcg_pkg::CW-1];
        if (ccw)
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ang;
        end
        else
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ang;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;

endmodule

// ----- sv/hmcg_cordic_chain.sv -----
// A row of CORDIC cells, one per iteration, with a valid and sideband shift line.
// Depends on hmcg_pkg and hmcg_cordic_cell.
module hmcg_cordic_chain (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            vectoring,
    input  logic            valid_in,
    input  hmcg_pkg::side_t side_in,
    input  hmcg_pkg::cw_t   x_in,
    input  hmcg_pkg::cw_t   y_in,
    input  hmcg_pkg::cw_t   z_in,
    output logic            valid_out,
    output hmcg_pkg::side_t side_out,
    output hmcg_pkg::cw_t   x_out,
    output hmcg_pkg::cw_t   y_out,
    output hmcg_pkg::cw_t   z_out
);

    localparam int N = hmcg_pkg::CORDIC_STEPS;

    hmcg_pkg::cw_t   xs [0:N];
    hmcg_pkg::cw_t   ys [0:N];
    hmcg_pkg::cw_t   zs [0:N];
    logic [N-1:0]    valid_reg;
    hmcg_pkg::side_t side_reg [0:N-1];

    assign xs[0] = x_in;
    assign ys[0] = y_in;
    assign zs[0] = z_in;

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        hmcg_cordic_cell u_cell (
            .clk       (clk),
            .en        (en),
            .vectoring (vectoring),
            .step      (hmcg_pkg::step_t'(i)),
            .x_in      (xs[i]),
            .y_in      (ys[i]),
            .z_in      (zs[i]),
            .x_out     (xs[i+1]),
            .y_out     (ys[i+1]),
            .z_out     (zs[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[N-2:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < N; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    assign valid_out = valid_reg[N-1];
    assign side_out  = side_reg[N-1];
    assign x_out     = xs[N];
    assign y_out     = ys[N];
    assign z_out     = zs[N];

endmodule

// ----- sv/hmcg_corner_pipe.sv -----
// Corner datapath: angle to turn conversion, sine and cosine chains, position
// products and the two vectoring chains for the texture coordinates.
// Depends on hmcg_pkg and hmcg_cordic_chain.
module hmcg_corner_pipe (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_in,
    input  logic [15:0]       radius,
    input  logic signed [17:0] t_ang,
    input  logic [15:0]       p_ang,
    output logic              valid_out,
    output hmcg_pkg::corner_t corner_out
);

    localparam int CW = hmcg_pkg::CW;

    // The azimuth plus its step can reach just over two turns, so a positive
    // angle may need the turn taken off twice.
    function automatic logic [15:0] reduce_angle(input logic signed [18:0] a);
        logic signed [18:0] w;
        w = a;
        if (w < 0)
        begin
            w = w + $signed(hmcg_pkg::FULL_ANGLE);
        end
        else
        begin
            if (w >= $signed(hmcg_pkg::FULL_ANGLE))
            begin
                w = w - $signed(hmcg_pkg::FULL_ANGLE);
            end
            if (w >= $signed(hmcg_pkg::FULL_ANGLE))
            begin
                w = w - $signed(hmcg_pkg::FULL_ANGLE);
            end
        end
        return w[15:0];
    endfunction

    function automatic logic signed [31:0] clamp_q30(input hmcg_pkg::cw_t v);
        logic signed [31:0] r;
        if (v > hmcg_pkg::Q30_ONE)
        begin
            r = 32'sd1073741824;
        end
        else if (v < -hmcg_pkg::Q30_ONE)
        begin
            r = -32'sd1073741824;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Valid bits of the stages outside the chains.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic v9_reg, v10_reg, v11_reg, v12_reg;

    // Stage 1: angle reduced to one turn.
    logic [15:0] tr_reg, pr_reg;
    // Stage 2: partial products of the turn conversion.
    logic [32:0] thi_reg, phi_reg;
    logic [47:0] tlo_reg, plo_reg;
    // Stage 3: binary angle.
    logic [31:0] tb_reg, pb_reg;
    // Stage 4: folded angle.
    hmcg_pkg::cw_t tz_reg, pz_reg;
    logic          tflip_reg, pflip_reg;
    // Stage 5: sine and cosine.
    logic signed [31:0] ts_reg, tc_reg, ps_reg, pc_reg;
    // Stage 6: unit vector products.
    logic signed [63:0] mx_reg, my_reg;
    logic signed [31:0] uz6_reg;
    // Stage 7: unit vector.
    logic signed [31:0] ux_reg, uy_reg, uz_reg;
    // Stage 8: radius products.
    logic signed [48:0] pxm_reg, pym_reg, pzm_reg;
    logic signed [31:0] ux8_reg, uy8_reg, uz8_reg;
    // Stage 9: positions and first vectoring start.
    hmcg_pkg::side_t side9_reg;
    hmcg_pkg::cw_t   v1x_reg, v1y_reg, v1z_reg;
    // Stage 10: u and magnitude product.
    hmcg_pkg::side_t side10_reg;
    logic [61:0]     mk_reg;
    hmcg_pkg::cw_t   uy10_reg;
    // Stage 11: second vectoring start.
    hmcg_pkg::side_t side11_reg;
    hmcg_pkg::cw_t   v2x_reg, v2y_reg;
    // Stage 12: result.
    hmcg_pkg::corner_t corner_reg;

    // Chain outputs.
    logic            tv_out, v1_out, v2_out;
    hmcg_pkg::side_t tside_out, v1side_out, v2side_out;
    hmcg_pkg::cw_t   tx_out, ty_out, px_out, py_out;
    hmcg_pkg::cw_t   v1x_out, v1z_out, v2z_out;
    hmcg_pkg::side_t tside_in;

    // Combinational next values.
    logic [20:0]        tn, pn;
    logic [32:0]        tsum, psum;
    hmcg_pkg::cw_t      tz_w, pz_w, tz_next, pz_next;
    logic               tflip_next, pflip_next;
    hmcg_pkg::cw_t      ts_raw, tc_raw, ps_raw, pc_raw;
    logic signed [63:0] mx_rnd, my_rnd;
    logic signed [48:0] pxr, pyr, pzr;
    hmcg_pkg::cw_t      uxw, uzw, v1x_next, v1y_next, v1z_next;
    logic [31:0]        a32;
    logic [32:0]        usum;
    logic [61:0]        mk_next, mk_rnd;
    hmcg_pkg::cw_t      bw;
    logic signed [31:0] bcl;
    logic signed [32:0] vsum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v5_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
            v11_reg <= 1'b0;
            v12_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg  <= valid_in;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v5_reg  <= tv_out;
            v6_reg  <= v5_reg;
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v1_out;
            v11_reg <= v10_reg;
            v12_reg <= v2_out;
        end
    end

    always_comb
    begin
        tn   = {5'b0, tr_reg} * hmcg_pkg::FIX_MUL + hmcg_pkg::FIX_ADD;
        pn   = {5'b0, pr_reg} * hmcg_pkg::FIX_MUL + hmcg_pkg::FIX_ADD;
        tsum = thi_reg + {17'b0, tlo_reg[47:32]};
        psum = phi_reg + {17'b0, plo_reg[47:32]};

        // Fold the angle into the quarter turns either side of zero.
        tz_w       = hmcg_pkg::cw_t'($signed(tb_reg));
        pz_w       = hmcg_pkg::cw_t'($signed(pb_reg));
        tz_next    = tz_w;
        pz_next    = pz_w;
        tflip_next = 1'b0;
        pflip_next = 1'b0;
        if (tz_w > hmcg_pkg::Q30_ONE)
        begin
            tz_next    = tz_w - hmcg_pkg::HALF_TURN;
            tflip_next = 1'b1;
        end
        else if (tz_w < -hmcg_pkg::Q30_ONE)
        begin
            tz_next    = tz_w + hmcg_pkg::HALF_TURN;
            tflip_next = 1'b1;
        end
        if (pz_w > hmcg_pkg::Q30_ONE)
        begin
            pz_next    = pz_w - hmcg_pkg::HALF_TURN;
            pflip_next = 1'b1;
        end
        else if (pz_w < -hmcg_pkg::Q30_ONE)
        begin
            pz_next    = pz_w + hmcg_pkg::HALF_TURN;
            pflip_next = 1'b1;
        end

        tside_in       = '0;
        tside_in.aux   = {30'b0, pflip_reg, tflip_reg};

        ts_raw = tside_out.aux[0] ? -ty_out : ty_out;
        tc_raw = tside_out.aux[0] ? -tx_out : tx_out;
        ps_raw = tside_out.aux[1] ? -py_out : py_out;
        pc_raw = tside_out.aux[1] ? -px_out : px_out;

        mx_rnd = (mx_reg + 64'sd536870912) >>> 30;
        my_rnd = (my_reg + 64'sd536870912) >>> 30;

        pxr = (pxm_reg + 49'sd2097152) >>> 22;
        pyr = (pym_reg + 49'sd2097152) >>> 22;
        pzr = (pzm_reg + 49'sd2097152) >>> 22;

        // The first vectoring works on (z, x); a negative z starts a half turn on.
        uxw = hmcg_pkg::cw_t'(ux8_reg);
        uzw = hmcg_pkg::cw_t'(uz8_reg);
        if (uzw < 0)
        begin
            v1x_next = -uzw;
            v1y_next = -uxw;
            v1z_next = hmcg_pkg::HALF_TURN;
        end
        else
        begin
            v1x_next = uzw;
            v1y_next = uxw;
            v1z_next = '0;
        end

        a32     = v1z_out[31:0];
        usum    = {1'b0, ~a32[31], a32[30:0]} + 33'd32768;
        mk_next = v1x_out[31:0] * hmcg_pkg::CORDIC_K[29:0];
        mk_rnd  = (mk_reg + 62'd536870912) >> 30;

        bw   = hmcg_pkg::cw_t'($signed(v2z_out[31:0]));
        bcl  = clamp_q30(bw);
        vsum = 33'(bcl) + 33'sd1073741824 + 33'sd16384;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tr_reg <= reduce_angle(19'(t_ang));
            pr_reg <= reduce_angle($signed({3'b0, p_ang}));

            thi_reg <= 33'(tr_reg) * 33'(hmcg_pkg::TURN_MUL);
            phi_reg <= 33'(pr_reg) * 33'(hmcg_pkg::TURN_MUL);
            tlo_reg <= 48'(tn) * 48'(hmcg_pkg::RECIP_45);
            plo_reg <= 48'(pn) * 48'(hmcg_pkg::RECIP_45);

            tb_reg <= tsum[31:0];
            pb_reg <= psum[31:0];

            tz_reg    <= tz_next;
            pz_reg    <= pz_next;
            tflip_reg <= tflip_next;
            pflip_reg <= pflip_next;

            ts_reg <= clamp_q30(ts_raw);
            tc_reg <= clamp_q30(tc_raw);
            ps_reg <= clamp_q30(ps_raw);
            pc_reg <= clamp_q30(pc_raw);

            mx_reg  <= 64'(ts_reg) * 64'(pc_reg);
            my_reg  <= 64'(tc_reg) * 64'(pc_reg);
            uz6_reg <= ps_reg;

            ux_reg <= clamp_q30(mx_rnd[CW-1:0]);
            uy_reg <= clamp_q30(my_rnd[CW-1:0]);
            uz_reg <= uz6_reg;

            pxm_reg <= $signed({1'b0, radius}) * ux_reg;
            pym_reg <= $signed({1'b0, radius}) * uy_reg;
            pzm_reg <= $signed({1'b0, radius}) * uz_reg;
            ux8_reg <= ux_reg;
            uy8_reg <= uy_reg;
            uz8_reg <= uz_reg;

            side9_reg.pos_x <= pxr[hmcg_pkg::POS_W-1:0];
            side9_reg.pos_y <= pyr[hmcg_pkg::POS_W-1:0];
            side9_reg.pos_z <= pzr[hmcg_pkg::POS_W-1:0];
            side9_reg.aux   <= uy8_reg;
            v1x_reg         <= v1x_next;
            v1y_reg         <= v1y_next;
            v1z_reg         <= v1z_next;

            side10_reg.pos_x <= v1side_out.pos_x;
            side10_reg.pos_y <= v1side_out.pos_y;
            side10_reg.pos_z <= v1side_out.pos_z;
            side10_reg.aux   <= {15'b0, usum[32:16]};
            mk_reg           <= mk_next;
            uy10_reg         <= hmcg_pkg::cw_t'($signed(v1side_out.aux));

            side11_reg <= side10_reg;
            v2x_reg    <= {2'b00, mk_rnd[31:0]};
            v2y_reg    <= uy10_reg;

            corner_reg.pos_x <= v2side_out.pos_x;
            corner_reg.pos_y <= v2side_out.pos_y;
            corner_reg.pos_z <= v2side_out.pos_z;
            corner_reg.tex_u <= v2side_out.aux[hmcg_pkg::UV_W-1:0];
            corner_reg.tex_v <= vsum[31:15];
        end
    end

    // Sine and cosine of the azimuth; this lane also carries the fold flags.
    hmcg_cordic_chain u_trig_t (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .vectoring (1'b0),
        .valid_in  (v4_reg),
        .side_in   (tside_in),
        .x_in      (hmcg_pkg::CORDIC_K),
        .y_in      ('0),
        .z_in      (tz_reg),
        .valid_out (tv_out),
        .side_out  (tside_out),
        .x_out     (tx_out),
        .y_out     (ty_out),
        .z_out     ()
    );

    // Sine and cosine of the elevation, in step with the azimuth lane.
    hmcg_cordic_chain u_trig_p (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .vectoring (1'b0),
        .valid_in  (v4_reg),
        .side_in   ('0),
        .x_in      (hmcg_pkg::CORDIC_K),
        .y_in      ('0),
        .z_in      (pz_reg),
        .valid_out (),
        .side_out  (),
        .x_out     (px_out),
        .y_out     (py_out),
        .z_out     ()
    );

    // Azimuth of the corner about the vertical axis, for u.
    hmcg_cordic_chain u_vec_u (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .vectoring (1'b1),
        .valid_in  (v9_reg),
        .side_in   (side9_reg),
        .x_in      (v1x_reg),
        .y_in      (v1y_reg),
        .z_in      (v1z_reg),
        .valid_out (v1_out),
        .side_out  (v1side_out),
        .x_out     (v1x_out),
        .y_out     (),
        .z_out     (v1z_out)
    );

    // Angle of y against the horizontal magnitude, for v.
    hmcg_cordic_chain u_vec_v (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .vectoring (1'b1),
        .valid_in  (v11_reg),
        .side_in   (side11_reg),
        .x_in      (v2x_reg),
        .y_in      (v2y_reg),
        .z_in      ('0),
        .valid_out (v2_out),
        .side_out  (v2side_out),
        .x_out     (),
        .y_out     (),
        .z_out     (v2z_out)
    );

    assign valid_out  = v12_reg;
    assign corner_out = corner_reg;

endmodule

// ----- sv/hemisphere_mesh_cell_generator.sv -----
// Hemisphere mesh cell generator: one grid cell word in, six vertex words out.
// Cells overlap in flight. Vertices leave one per cycle while out_ready is high; the
// path to the first vertex is mostly the three 30-cell CORDIC rows in series of the
// corner datapath, which takes one corner per cycle unless a finished corner has
// nowhere to go. Reset (rst_n low, asynchronous) empties the pipeline and loads
// radius 100 and both angle steps 1280. Depends on hmcg_pkg and hmcg_corner_pipe.
module hemisphere_mesh_cell_generator (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] azimuth_start,
    input  logic [13:0]        elevation_start,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         vertex_slot,
    output logic signed [24:0] pos_x,
    output logic signed [24:0] pos_y,
    output logic signed [24:0] pos_z,
    output logic [16:0]        tex_u,
    output logic [16:0]        tex_v,
    output logic               last
);

    // Corner used by each vertex slot: triangles {0,1,2} and {1,2,3}.
    function automatic logic [1:0] corner_of(input logic [2:0] slot);
        logic [1:0] c;
        case (slot)
            3'd0:    c = 2'd0;
            3'd1:    c = 2'd1;
            3'd2:    c = 2'd2;
            3'd3:    c = 2'd1;
            3'd4:    c = 2'd2;
            3'd5:    c = 2'd3;
            default: c = 2'd0;
        endcase
        return c;
    endfunction

    // Configuration registers.
    logic [15:0] radius_reg;
    logic [15:0] az_step_reg;
    logic [13:0] el_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg  <= hmcg_pkg::RADIUS_RESET;
            az_step_reg <= hmcg_pkg::AZ_STEP_RESET;
            el_step_reg <= hmcg_pkg::EL_STEP_RESET;
        end
        else if (cfg_write_en)
        begin
            unique case (hmcg_pkg::cfg_reg_t'(cfg_index))
                hmcg_pkg::REG_RADIUS:  radius_reg  <= cfg_data;
                hmcg_pkg::REG_AZ_STEP: az_step_reg <= cfg_data;
                hmcg_pkg::REG_EL_STEP: el_step_reg <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // The input word is held while its four corners are issued into the
    // datapath, one per cycle while it advances. Corner bit 1 adds the azimuth
    // step, bit 0 the elevation step. The next word is taken in the cycle the last corner goes.
    logic               hold_valid_reg;
    logic [1:0]         corner_cnt_reg;
    logic signed [15:0] hold_t_reg;
    logic [13:0]        hold_p_reg;
    logic               adv;
    logic               issue;
    logic               last_corner;
    logic signed [17:0] t_ang;
    logic [15:0]        p_ang;

    assign issue       = hold_valid_reg && adv;
    assign last_corner = (corner_cnt_reg == 2'd3);
    assign in_ready    = !hold_valid_reg || (issue && last_corner);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            corner_cnt_reg <= 2'd0;
        end
        else if (in_valid && in_ready)
        begin
            hold_valid_reg <= 1'b1;
            corner_cnt_reg <= 2'd0;
        end
        else if (issue)
        begin
            if (last_corner)
            begin
                hold_valid_reg <= 1'b0;
            end
            corner_cnt_reg <= corner_cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            hold_t_reg <= azimuth_start;
            hold_p_reg <= elevation_start;
        end
    end

    always_comb
    begin
        t_ang = 18'(hold_t_reg);
        p_ang = {2'b00, hold_p_reg};
        if (corner_cnt_reg[1])
        begin
            t_ang = t_ang + $signed({2'b00, az_step_reg});
        end
        if (corner_cnt_reg[0])
        begin
            p_ang = p_ang + {2'b00, el_step_reg};
        end
    end

    // Corner datapath. The whole pipeline advances together and stalls only
    // when a finished corner has nowhere to go.
    logic              pipe_valid;
    hmcg_pkg::corner_t pipe_corner;

    hmcg_corner_pipe u_corner_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .valid_in   (issue),
        .radius     (radius_reg),
        .t_ang      (t_ang),
        .p_ang      (p_ang),
        .valid_out  (pipe_valid),
        .corner_out (pipe_corner)
    );

    // Corners gather in a collector bank; a full bank moves to the emit bank
    // as soon as the emit bank is idle or sends its sixth vertex, so the next cell's
    // corners can gather while the current cell is being sent.
    hmcg_pkg::corner_t coll_reg [0:3];
    logic [2:0]        coll_cnt_reg;
    hmcg_pkg::corner_t emit_reg [0:3];
    logic              emit_valid_reg;
    logic [2:0]        slot_reg;
    logic              emit_free;
    logic              xfer;
    logic              can_write;
    logic              coll_write;
    logic [1:0]        coll_idx;
    hmcg_pkg::corner_t cur;

    assign emit_free  = !emit_valid_reg || (out_ready && slot_reg == 3'd5);
    assign xfer       = (coll_cnt_reg == 3'd4) && emit_free;
    assign can_write  = (coll_cnt_reg != 3'd4) || xfer;
    assign adv        = !pipe_valid || can_write;
    assign coll_write = pipe_valid && can_write;
    assign coll_idx   = xfer ? 2'd0 : coll_cnt_reg[1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coll_cnt_reg <= 3'd0;
        end
        else if (coll_write)
        begin
            coll_cnt_reg <= (xfer ? 3'd0 : coll_cnt_reg) + 3'd1;
        end
        else if (xfer)
        begin
            coll_cnt_reg <= 3'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (coll_write)
        begin
            coll_reg[coll_idx] <= pipe_corner;
        end
        if (xfer)
        begin
            for (int i = 0; i < 4; i++)
            begin
                emit_reg[i] <= coll_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_valid_reg <= 1'b0;
            slot_reg       <= 3'd0;
        end
        else if (xfer)
        begin
            emit_valid_reg <= 1'b1;
            slot_reg       <= 3'd0;
        end
        else if (emit_valid_reg && out_ready)
        begin
            if (slot_reg == 3'd5)
            begin
                emit_valid_reg <= 1'b0;
            end
            else
            begin
                slot_reg <= slot_reg + 3'd1;
            end
        end
    end

    assign cur         = emit_reg[corner_of(slot_reg)];
    assign out_valid   = emit_valid_reg;
    assign vertex_slot = slot_reg;
    assign pos_x       = cur.pos_x;
    assign pos_y       = cur.pos_y;
    assign pos_z       = cur.pos_z;
    assign tex_u       = cur.tex_u;
    assign tex_v       = cur.tex_v;
    assign last        = (slot_reg == 3'd5);

endmodule
